// ===== src/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg: shared types for the 2bpp glyph row repacker
// Item format passed from the front classifier to the packing back end.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

  // Number of pixels kept from one source byte: 1..4
  typedef logic [2:0] px_count_t;

  // Classified source byte, as queued between front and back
  typedef struct packed {
    logic [7:0] src;        // source byte, first pixel in bits 7:6
    px_count_t  count;      // pixels inside the glyph width
    logic       clear;      // first byte of a glyph: drop packing state
    logic       glyph_end;  // last source byte of the glyph: flush
  } work_item_t;

  // One packed output item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/grr_front.sv =====
// ----------------------------------------------------------------------------
// grr_front: source byte classifier
// Tracks glyph size, column and row; decides how many pixels of each byte
// are kept and whether the byte ends the glyph. Ignored bytes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        aligned_byte,
  input  wire logic [7:0]        glyph_width,
  input  wire logic [7:0]        glyph_height,
  input  wire logic              first_of_glyph,
  input  wire logic              q_full,
  output logic                   push,
  output grr_pkg::work_item_t    push_item
);

  logic [7:0] held_width;
  logic [7:0] held_height;
  logic [5:0] column_byte;
  logic [7:0] row_index;

  logic [7:0] width_eff;
  logic [7:0] height_eff;
  logic [5:0] col_eff;
  logic [7:0] row_eff;
  logic [6:0] stride;
  logic       active;
  logic       last_col;
  logic       accept;
  logic [7:0] width_m1;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // effective glyph state after a possible restart
  always_comb begin
    if (first_of_glyph) begin
      width_eff  = glyph_width;
      height_eff = glyph_height;
      col_eff    = 6'd0;
      row_eff    = 8'd0;
    end else begin
      width_eff  = held_width;
      height_eff = held_height;
      col_eff    = column_byte;
      row_eff    = row_index;
    end
    width_m1 = width_eff - 8'd1;
    stride   = 7'((9'({1'b0, width_eff}) + 9'd3) >> 2);
    active   = (width_eff != 8'd0) && (height_eff != 8'd0) && (row_eff < height_eff);
    last_col = (7'({1'b0, col_eff}) + 7'd1) >= stride;
  end

  // classified item for the back end
  always_comb begin
    push_item.src       = aligned_byte;
    push_item.count     = last_col ? (3'({1'b0, width_m1[1:0]}) + 3'd1) : 3'd4;
    push_item.clear     = first_of_glyph;
    push_item.glyph_end = last_col && ((row_eff + 8'd1) == height_eff);
    push                = accept && active;
  end

  // position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      held_width  <= 8'd0;
      held_height <= 8'd0;
      column_byte <= 6'd0;
      row_index   <= 8'd0;
    end else if (accept) begin
      held_width  <= width_eff;
      held_height <= height_eff;
      if (active && last_col) begin
        column_byte <= 6'd0;
        row_index   <= row_eff + 8'd1;
      end else if (active) begin
        column_byte <= col_eff + 6'd1;
        row_index   <= row_eff;
      end else begin
        column_byte <= col_eff;
        row_index   <= row_eff;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/grr_fifo.sv =====
// ----------------------------------------------------------------------------
// grr_fifo: small queue between classifier and packer
// Register-based FIFO; full is derived from the stored count only.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire grr_pkg::work_item_t push_item,
  output logic                     full,
  output logic                     q_valid,
  input  wire logic                pop,
  output grr_pkg::work_item_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grr_pkg::work_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // queue never overruns or underruns
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("grr_fifo: push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("grr_fifo: pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("grr_fifo: count out of range");

endmodule

`default_nettype wire

// ===== src/grr_back.sv =====
// ----------------------------------------------------------------------------
// grr_back: pixel packer and output stage
// Joins pending pixels with the kept pixels of each item, emits up to two
// bytes per item through an output register and one spare slot.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire grr_pkg::work_item_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               packed_byte,
  output logic                     last_of_glyph
);

  logic [5:0] pixel_accumulator;
  logic [2:0] pending_bits;

  grr_pkg::out_item_t out_reg;
  grr_pkg::out_item_t spare_reg;
  logic               spare_valid;

  logic [5:0]  acc_eff;
  logic [2:0]  bits_eff;
  logic [3:0]  px_bits;
  logic [13:0] wide;
  logic [3:0]  total;
  logic [3:0]  sh;
  logic [2:0]  rem_bits;
  logic [5:0]  rem_mask;
  logic [5:0]  rem;
  logic        full_byte;
  grr_pkg::out_item_t res1;
  grr_pkg::out_item_t res2;
  logic        has1;
  logic        has2;
  logic [5:0]  pixel_accumulator_next;
  logic [2:0]  pending_bits_next;
  logic        out_free;

  assign out_free      = !out_valid || !out_stall;
  assign pop           = q_valid && !spare_valid && out_free;
  assign packed_byte   = out_reg.data;
  assign last_of_glyph = out_reg.last;

  // combine pending pixels with this item
  always_comb begin
    acc_eff   = head.clear ? 6'd0 : pixel_accumulator;
    bits_eff  = head.clear ? 3'd0 : pending_bits;
    px_bits   = {head.count, 1'b0};
    wide      = (14'(acc_eff) << px_bits) | (14'(head.src) >> (4'd8 - px_bits));
    total     = 4'(bits_eff) + px_bits;
    full_byte = total >= 4'd8;
    sh        = full_byte ? (total - 4'd8) : 4'd0;
    rem_bits  = full_byte ? sh[2:0] : total[2:0];
    rem_mask  = (6'd1 << rem_bits) - 6'd1;
    rem       = wide[5:0] & rem_mask;

    res1.data = 8'(wide >> sh);
    res1.last = 1'b0;
    res2.data = 8'({2'b00, rem} << (4'd8 - 4'(rem_bits)));
    res2.last = 1'b1;
    has1      = full_byte;
    has2      = 1'b0;
    pixel_accumulator_next = rem;
    pending_bits_next      = rem_bits;

    // glyph end: flush remainder and mark the final byte
    if (head.glyph_end) begin
      pixel_accumulator_next = 6'd0;
      pending_bits_next      = 3'd0;
      if (full_byte) begin
        if (rem_bits != 3'd0) begin
          has2 = 1'b1;
        end else begin
          res1.last = 1'b1;
        end
      end else begin
        has1      = 1'b1;
        res1.data = wide[7:0] << (4'd8 - total);
        res1.last = 1'b1;
      end
    end
  end

  // packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_accumulator <= 6'd0;
      pending_bits      <= 3'd0;
    end else if (pop) begin
      pixel_accumulator <= pixel_accumulator_next;
      pending_bits      <= pending_bits_next;
    end
  end

  // output register and spare slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_free) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else if (pop) begin
        out_valid   <= has1;
        spare_valid <= has2;
      end else begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (spare_valid) begin
        out_reg <= spare_reg;
      end else if (pop) begin
        out_reg   <= res1;
        spare_reg <= res2;
      end
    end
  end

  // spare slot only fills behind a held output byte
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("grr_back: spare byte without output byte");
  // pending bit count stays an even number below a byte
  a_bits_even: assert property (@(posedge clk) disable iff (rst)
    !pending_bits[0] && (pending_bits != 3'd7))
    else $error("grr_back: bad pending bit count");
  // a glyph end leaves no pending pixels
  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    pop && head.glyph_end |=> pending_bits == 3'd0)
    else $error("grr_back: pixels left after glyph end");
  // a double result is never a spare byte without the last mark
  a_spare_last: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> spare_reg.last)
    else $error("grr_back: spare byte not marked last");

endmodule

`default_nettype wire

// ===== src/glyph_2bpp_row_repack_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_2bpp_row_repack_unit: 2bpp glyph row padding removal
// Strips the byte padding at the end of each glyph row and repacks pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one row-aligned source byte per
//   item with the glyph width, height and a first-of-glyph flag. Output
//   channel (out_valid / out_stall) gives packed bytes; the final byte of a
//   glyph carries last_of_glyph.
//   Throughput: one source byte per cycle while the queue is not full. A
//   byte that yields two packed bytes (only the glyph's last byte, when it
//   completes one byte and flushes a partial one) puts the second in the
//   spare slot, which holds the packer until it moves to the output register.
//   Path from an accepted byte to its first packed byte: classifier into the
//   queue, packer into the output register.
//   Bytes outside a glyph, or with zero width or height, give no output.
//   Reset clears the glyph position, the packing state, the queue and the
//   output stage; bytes before the first first_of_glyph are ignored.
//   When the receiver stalls the output byte holds; the queue fills and
//   in_stall rises once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_2bpp_row_repack_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  aligned_byte,
  input  wire logic [7:0]  glyph_width,
  input  wire logic [7:0]  glyph_height,
  input  wire logic        first_of_glyph,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       packed_byte,
  output logic             last_of_glyph
);

  logic                q_full;
  logic                push;
  grr_pkg::work_item_t push_item;
  logic                q_valid;
  logic                pop;
  grr_pkg::work_item_t head;

  // classifier
  grr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .aligned_byte   (aligned_byte),
    .glyph_width    (glyph_width),
    .glyph_height   (glyph_height),
    .first_of_glyph (first_of_glyph),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  // decoupling queue
  grr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .head      (head)
  );

  // packer and output stage
  grr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .packed_byte   (packed_byte),
    .last_of_glyph (last_of_glyph)
  );

endmodule

`default_nettype wire

// ===== bench/glyph_repack_checker.sv =====
// ----------------------------------------------------------------------------
// glyph_repack_checker: predicts and checks packed glyph bytes
// Watches both channels of the 2bpp row repacker. Each accepted source byte
// goes through a bit-exact copy of the padding removal and packing. The
// packed bytes it gives are queued, and every accepted output byte is
// compared field by field with the oldest queued byte.
// ----------------------------------------------------------------------------
module glyph_repack_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] aligned_byte,
  input  logic [7:0] glyph_width,
  input  logic [7:0] glyph_height,
  input  logic       first_of_glyph,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] packed_byte,
  input  logic       last_of_glyph,
  output int         fail_count,
  output int         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Packed bytes still owed by the block, oldest first
  grr_pkg::out_item_t packed_due[$];
  int                 errors = 0;

  // Predictor state, at the block's widths
  logic [5:0] acc_q = '0;
  logic [2:0] bits_q = '0;
  logic [5:0] col_q = '0;
  logic [7:0] row_q = '0;
  logic [7:0] wid_q = '0;
  logic [7:0] hgt_q = '0;

  // Strip row padding from one source byte and queue the packed bytes it yields
  task automatic predict_repack(input logic [7:0] src, input logic [7:0] w,
                                input logic [7:0] h, input logic first);
    int                 stride;
    int                 count;
    int                 bits;
    int                 next_col;
    int                 n_out;
    logic [7:0]         acc;
    grr_pkg::out_item_t item;
    if (first) begin
      wid_q  = w;
      hgt_q  = h;
      acc_q  = '0;
      bits_q = '0;
      col_q  = '0;
      row_q  = '0;
    end
    // empty glyph, or glyph already complete: ignored
    if (wid_q == 0 || hgt_q == 0 || row_q >= hgt_q) return;

    stride = (int'(wid_q) + 3) / 4;
    count  = (int'(col_q) + 1 < stride) ? 4 : ((int'(wid_q) - 1) % 4) + 1;
    acc    = {2'b00, acc_q};
    bits   = int'(bits_q);
    n_out  = 0;
    for (int k = 0; k < count; k++) begin
      acc  = {acc[5:0], src[7 - 2 * k -: 2]};
      bits = bits + 2;
      if (bits == 8) begin
        item.data = acc;
        item.last = 1'b0;
        packed_due.push_back(item);
        n_out++;
        acc  = '0;
        bits = 0;
      end
    end

    // advance column, wrap into next row
    next_col = int'(col_q) + 1;
    if (next_col >= stride) begin
      col_q = '0;
      row_q = row_q + 8'd1;
    end else begin
      col_q = 6'(next_col);
    end

    // glyph end: flush partial byte, or mark the last full one
    if (row_q == hgt_q) begin
      if (bits > 0) begin
        item.data = acc << (8 - bits);
        item.last = 1'b1;
        packed_due.push_back(item);
      end else if (n_out > 0) begin
        packed_due[packed_due.size() - 1].last = 1'b1;
      end
      acc  = '0;
      bits = 0;
    end

    acc_q  = acc[5:0];
    bits_q = 3'(bits);
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    grr_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        predict_repack(aligned_byte, glyph_width, glyph_height, first_of_glyph);
      if (out_valid && !out_stall) begin
        if (packed_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: expected none, actual packed_byte %02h last %0b",
                   $time, packed_byte, last_of_glyph);
        end else begin
          want = packed_due.pop_front();
          if (packed_byte !== want.data) begin
            errors++;
            $display("%0t: packed_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, packed_byte);
          end
          if (last_of_glyph !== want.last) begin
            errors++;
            $display("%0t: last_of_glyph mismatch: expected %0b, actual %0b",
                     $time, want.last, last_of_glyph);
          end
        end
      end
    end
    fail_count      <= errors;
    pending_results <= packed_due.size();
  end

endmodule

// ===== bench/glyph_2bpp_row_repack_unit_test.sv =====
// ----------------------------------------------------------------------------
// glyph_2bpp_row_repack_unit_test: bench top for the 2bpp row repacker
// Drives directed glyphs (extreme sizes, empty glyphs, stray and trailing
// bytes, abandoned glyphs) and then random glyph streams with random idle on
// the input, stall on the output. Checking is done by glyph_repack_checker.
// ----------------------------------------------------------------------------
module glyph_2bpp_row_repack_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;  // cycles with no item moving
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] aligned_byte = '0;
  logic [7:0] glyph_width = '0;
  logic [7:0] glyph_height = '0;
  logic       first_of_glyph = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] packed_byte;
  logic       last_of_glyph;

  int fail_count;
  int pending_results;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;  // no idle and no stall while set

  glyph_2bpp_row_repack_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .aligned_byte   (aligned_byte),
    .glyph_width    (glyph_width),
    .glyph_height   (glyph_height),
    .first_of_glyph (first_of_glyph),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .packed_byte    (packed_byte),
    .last_of_glyph  (last_of_glyph)
  );

  glyph_repack_checker repack_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .aligned_byte    (aligned_byte),
    .glyph_width     (glyph_width),
    .glyph_height    (glyph_height),
    .first_of_glyph  (first_of_glyph),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .packed_byte     (packed_byte),
    .last_of_glyph   (last_of_glyph),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver stalls now and then
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  // No item moving on either channel for too long: give up
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("glyph_2bpp_row_repack_unit test failed");
      $finish;
    end
  end

  // Source bytes in one glyph
  function automatic int glyph_bytes(input int w, input int h);
    return ((w + 3) / 4) * h;
  endfunction

  // One source item, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic [7:0] w,
                           input logic [7:0] h, input logic f);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    aligned_byte   <= b;
    glyph_width    <= w;
    glyph_height   <= h;
    first_of_glyph <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // First nbytes of a glyph; later bytes sometimes carry junk width/height
  task automatic send_glyph(input int w, input int h, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (i > 0 && $urandom_range(3) == 0)
        send_byte(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      else
        send_byte(8'($urandom), 8'(w), 8'(h), i == 0);
    end
  endtask

  // Stray bytes with no glyph start
  task automatic send_noise(input int nbytes);
    for (int i = 0; i < nbytes; i++)
      send_byte(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  initial begin
    int r;
    int w;
    int h;
    int total;
    int stop_at;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ---
    // bytes before any glyph start
    send_byte(8'hFF, 8'd7, 8'd2, 1'b0);
    send_byte(8'h00, 8'd255, 8'd255, 1'b0);
    // single pixel glyph
    send_byte(8'hFF, 8'd1, 8'd1, 1'b1);
    // width divisible by four: pass through
    send_byte(8'hA5, 8'd4, 8'd1, 1'b1);
    // last byte completes one byte and flushes a partial one
    send_byte(8'hFC, 8'd3, 8'd2, 1'b1);
    send_byte(8'h57, 8'd3, 8'd2, 1'b0);
    // zero width, zero height
    send_byte(8'hFF, 8'd0, 8'd3, 1'b1);
    send_byte(8'h12, 8'd0, 8'd3, 1'b0);
    send_byte(8'hFF, 8'd5, 8'd0, 1'b1);
    // width/height changing mid glyph, then bytes past glyph end
    send_byte(8'h1B, 8'd6, 8'd2, 1'b1);
    send_byte(8'hE4, 8'd200, 8'd9, 1'b0);
    send_byte(8'h3C, 8'd1, 8'd255, 1'b0);
    send_byte(8'hC3, 8'd6, 8'd2, 1'b0);
    send_byte(8'hFF, 8'd6, 8'd2, 1'b0);
    send_byte(8'h81, 8'd6, 8'd2, 1'b0);
    // glyph abandoned by an early start
    send_byte(8'hFF, 8'd9, 8'd3, 1'b1);
    send_byte(8'hAA, 8'd9, 8'd3, 1'b0);
    send_byte(8'h55, 8'd9, 8'd3, 1'b0);
    send_byte(8'hD2, 8'd2, 8'd3, 1'b1);
    send_byte(8'h7F, 8'd2, 8'd3, 1'b0);
    send_byte(8'h80, 8'd2, 8'd3, 1'b0);
    // full width bytes of all zeros and all ones
    send_byte(8'h00, 8'd8, 8'd2, 1'b1);
    send_byte(8'hFF, 8'd8, 8'd2, 1'b0);
    send_byte(8'hFF, 8'd8, 8'd2, 1'b0);
    send_byte(8'h00, 8'd8, 8'd2, 1'b0);

    // --- random ---
    stop_at = items_sent + RANDOM_ITEMS;
    // widest single row, tallest single column
    send_glyph(255, 1, glyph_bytes(255, 1));
    send_glyph(1, 255, glyph_bytes(1, 255));
    while (items_sent < stop_at) begin
      calm = (items_sent >= stop_at - 500) && (items_sent < stop_at - 350);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(17, 255);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 6);
      end
      total = glyph_bytes(w, h);
      r = $urandom_range(99);
      if (r < 75) begin
        send_glyph(w, h, total);
      end else if (r < 85) begin
        send_glyph(w, h, (total > 1) ? $urandom_range(1, total - 1) : total);
      end else if (r < 93) begin
        send_glyph(w, h, total);
        send_noise($urandom_range(1, 3));
      end else begin
        if ($urandom_range(1) == 0)
          send_glyph(0, h, $urandom_range(1, 3));
        else
          send_glyph(w, 0, $urandom_range(1, 3));
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("glyph_2bpp_row_repack_unit test passed");
    end else begin
      $display("glyph_2bpp_row_repack_unit test failed");
    end
    $finish;
  end

endmodule
